// ===== design/dlpd_pkg.sv =====
// Shared types and constants for the debug line program decoder.
`timescale 1ns / 1ps
package dlpd_pkg;

    typedef struct packed {
        logic [7:0] program_byte;
        logic       unit_start;
    } in_word_t;

    typedef struct packed {
        logic [63:0] row_address;
        logic [31:0] row_file;
        logic [31:0] row_line;
        logic [15:0] row_column;
        logic        row_is_stmt;
        logic        row_basic_block;
        logic        row_end_sequence;
        logic        row_prologue_end;
        logic        row_epilogue_begin;
        logic [7:0]  row_isa;
        logic [31:0] row_discriminator;
        logic        decode_error;
    } out_word_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_INST_LEN  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_OPS       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEFAULT_STMT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_BASE     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_RANGE    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_SPECIAL = 3'd5;

    // Steps of the shared divider and the serial multiplier.
    localparam int DIV_STEPS = 64;
    localparam int MUL_STEPS = 8;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STEP,
        CMD_DIV,
        CMD_LINE,
        CMD_FIX,
        CMD_MUL,
        CMD_COMMIT
    } cmd_code_t;

    typedef enum logic [1:0] {
        SEQ_NONE,
        SEQ_SPECIAL,
        SEQ_CONST,
        SEQ_ADVANCE
    } seq_kind_t;

    typedef struct packed {
        cmd_code_t code;
        logic      div_by_range;
        logic      special;
    } dp_cmd_t;

    typedef struct packed {
        seq_kind_t seq;
        logic      out_busy;
    } dp_status_t;

endpackage

// ===== design/dlpd_ctrl.sv =====
// Controller that sequences decode steps, divisions and the address multiply.
`timescale 1ns / 1ps
module dlpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dlpd_pkg::dp_status_t status,
    output dlpd_pkg::dp_cmd_t    cmd
);
    import dlpd_pkg::*;

    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);
    localparam logic [5:0] MUL_LAST = 6'(MUL_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_DIV,
        S_LINE,
        S_FIX,
        S_MUL,
        S_COMMIT
    } state_t;

    state_t    state_reg;
    logic [5:0] cnt_reg;
    logic      range_reg;
    logic      special_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            range_reg   <= 1'b0;
            special_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:
                begin
                    if (!status.out_busy)
                    begin
                        cnt_reg     <= '0;
                        range_reg   <= (status.seq != SEQ_ADVANCE);
                        special_reg <= (status.seq == SEQ_SPECIAL);
                        state_reg   <= (status.seq == SEQ_NONE) ? S_IDLE : S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= range_reg ? S_LINE : S_FIX;
                    end
                end
                S_LINE:
                begin
                    cnt_reg   <= '0;
                    range_reg <= 1'b0;
                    state_reg <= S_DIV;
                end
                S_FIX:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.div_by_range = range_reg;
        cmd.special      = special_reg;
        unique case (state_reg)
            S_IDLE:   cmd.code = in_valid ? CMD_LOAD : CMD_NONE;
            S_STEP:   cmd.code = status.out_busy ? CMD_NONE : CMD_STEP;
            S_DIV:    cmd.code = CMD_DIV;
            S_LINE:   cmd.code = CMD_LINE;
            S_FIX:    cmd.code = CMD_FIX;
            S_MUL:    cmd.code = CMD_MUL;
            S_COMMIT: cmd.code = CMD_COMMIT;
            default:  cmd.code = CMD_NONE;
        endcase
    end

endmodule

// ===== design/dlpd_datapath.sv =====
// Datapath: line state registers, opcode decode, divider, multiplier and row register.
`timescale 1ns / 1ps
module dlpd_datapath #(
    parameter int AW = 64,
    parameter int LB = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dlpd_pkg::in_word_t                     in_data,
    input  logic                                   cfg_we,
    input  logic [dlpd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dlpd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  dlpd_pkg::dp_cmd_t                      cmd,
    output dlpd_pkg::dp_status_t                   status,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output dlpd_pkg::out_word_t                    out_data
);
    import dlpd_pkg::*;

    localparam logic [7:0] OP_EXTENDED      = 8'd0;
    localparam logic [7:0] OP_COPY          = 8'd1;
    localparam logic [7:0] OP_ADVANCE_PC    = 8'd2;
    localparam logic [7:0] OP_ADVANCE_LINE  = 8'd3;
    localparam logic [7:0] OP_SET_FILE      = 8'd4;
    localparam logic [7:0] OP_SET_COLUMN    = 8'd5;
    localparam logic [7:0] OP_NEGATE_STMT   = 8'd6;
    localparam logic [7:0] OP_BASIC_BLOCK   = 8'd7;
    localparam logic [7:0] OP_CONST_ADD_PC  = 8'd8;
    localparam logic [7:0] OP_FIXED_ADV_PC  = 8'd9;
    localparam logic [7:0] OP_PROLOGUE_END  = 8'd10;
    localparam logic [7:0] OP_EPILOGUE_BEG  = 8'd11;
    localparam logic [7:0] OP_SET_ISA       = 8'd12;
    localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
    localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;
    localparam logic [7:0] EXT_DEFINE_FILE  = 8'd3;
    localparam logic [7:0] EXT_SET_DISCRIM  = 8'd4;
    localparam logic [7:0] SPECIAL_TOP      = 8'd255;

    localparam int FL_STMT = 0;
    localparam int FL_BB   = 1;
    localparam int FL_END  = 2;
    localparam int FL_PRO  = 3;
    localparam int FL_EPI  = 4;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEB,
        PH_FIX_LO,
        PH_FIX_HI,
        PH_EXT_LEN,
        PH_EXT_SUB,
        PH_EXT_BODY
    } phase_t;

    // Configuration registers.
    logic [7:0]        min_len_reg;
    logic [7:0]        max_ops_reg;
    logic              def_stmt_reg;
    logic signed [7:0] line_base_reg;
    logic [7:0]        line_range_reg;
    logic [7:0]        first_spec_reg;

    // Line state and decoder state.
    logic [AW-1:0] addr_reg,    addr_next;
    logic [7:0]    op_idx_reg,  op_idx_next;
    logic [31:0]   file_reg,    file_next;
    logic [LB-1:0] line_reg,    line_next;
    logic [15:0]   col_reg,     col_next;
    logic [7:0]    isa_reg,     isa_next;
    logic [31:0]   disc_reg,    disc_next;
    logic [4:0]    flags_reg,   flags_next;
    phase_t        phase_reg,   phase_next;
    logic [63:0]   accum_reg,   accum_next;
    logic [6:0]    shift_reg,   shift_next;
    logic [31:0]   rem_reg,     rem_next;
    logic [7:0]    pend_reg,    pend_next;
    logic          leb_done_reg, leb_done_next;
    logic          err_reg,     err_next;

    // Latched input word and arithmetic registers.
    logic [7:0]    byte_reg;
    logic          start_reg;
    logic [63:0]   dvd_reg,     dvd_next;
    logic [7:0]    drem_reg,    drem_next;
    logic [63:0]   mcand_reg,   mcand_next;
    logic [63:0]   prod_reg,    prod_next;
    logic [7:0]    mplier_reg,  mplier_next;
    logic [7:0]    tidx_reg,    tidx_next;

    out_word_t     out_reg,     out_next;
    logic          out_valid_reg, out_valid_next;
    logic          emit;
    seq_kind_t     seq;

    logic [7:0]    range_eff;
    logic [7:0]    mops_eff;

    function automatic out_word_t make_row(
        input logic [AW-1:0] a,
        input logic [31:0]   f,
        input logic [LB-1:0] l,
        input logic [15:0]   c,
        input logic [4:0]    fl,
        input logic [7:0]    i,
        input logic [31:0]   d,
        input logic          e
    );
        out_word_t r;
        r.row_address        = 64'(a);
        r.row_file           = f;
        r.row_line           = 32'(l);
        r.row_column         = c;
        r.row_is_stmt        = fl[FL_STMT];
        r.row_basic_block    = fl[FL_BB];
        r.row_end_sequence   = fl[FL_END];
        r.row_prologue_end   = fl[FL_PRO];
        r.row_epilogue_begin = fl[FL_EPI];
        r.row_isa            = i;
        r.row_discriminator  = d;
        r.decode_error       = e;
        return r;
    endfunction

    assign range_eff = (line_range_reg == 8'd0) ? 8'd1 : line_range_reg;
    assign mops_eff  = (max_ops_reg == 8'd0) ? 8'd1 : max_ops_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg    <= 8'd1;
            max_ops_reg    <= 8'd1;
            def_stmt_reg   <= 1'b1;
            line_base_reg  <= -8'sd5;
            line_range_reg <= 8'd14;
            first_spec_reg <= 8'd13;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_INST_LEN:  min_len_reg    <= cfg_data;
                CFG_MAX_OPS:       max_ops_reg    <= cfg_data;
                CFG_DEFAULT_STMT:  def_stmt_reg   <= cfg_data[0];
                CFG_LINE_BASE:     line_base_reg  <= cfg_data;
                CFG_LINE_RANGE:    line_range_reg <= cfg_data;
                CFG_FIRST_SPECIAL: first_spec_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        logic [AW-1:0] b_addr;
        logic [7:0]    b_op;
        logic [31:0]   b_file;
        logic [LB-1:0] b_line;
        logic [15:0]   b_col;
        logic [7:0]    b_isa;
        logic [31:0]   b_disc;
        logic [4:0]    b_flags;
        phase_t        b_phase;
        logic [63:0]   b_accum;
        logic [6:0]    b_shift;
        logic [31:0]   b_rem;
        logic [7:0]    b_pend;
        logic          b_leb_done;
        logic          b_err;
        logic [7:0]    b;
        logic [63:0]   leb_acc;
        logic [6:0]    leb_shift;
        logic          leb_last;
        logic [63:0]   v;
        logic [31:0]   r_dec;
        logic [7:0]    d_sel;
        logic [8:0]    r9;
        logic [8:0]    t9;
        logic          qbit;

        addr_next     = addr_reg;
        op_idx_next   = op_idx_reg;
        file_next     = file_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        isa_next      = isa_reg;
        disc_next     = disc_reg;
        flags_next    = flags_reg;
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        shift_next    = shift_reg;
        rem_next      = rem_reg;
        pend_next     = pend_reg;
        leb_done_next = leb_done_reg;
        err_next      = err_reg;
        dvd_next      = dvd_reg;
        drem_next     = drem_reg;
        mcand_next    = mcand_reg;
        prod_next     = prod_reg;
        mplier_next   = mplier_reg;
        tidx_next     = tidx_reg;
        out_next      = out_reg;
        emit          = 1'b0;
        seq           = SEQ_NONE;

        // A unit start puts the line state back to its initial values before the byte, with is_stmt from the default.
        b          = byte_reg;
        b_addr     = start_reg ? '0 : addr_reg;
        b_op       = start_reg ? 8'd0 : op_idx_reg;
        b_file     = start_reg ? 32'd1 : file_reg;
        b_line     = start_reg ? LB'(1) : line_reg;
        b_col      = start_reg ? 16'd0 : col_reg;
        b_isa      = start_reg ? 8'd0 : isa_reg;
        b_disc     = start_reg ? 32'd0 : disc_reg;
        b_flags    = start_reg ? {4'd0, def_stmt_reg} : flags_reg;
        b_phase    = start_reg ? PH_OPCODE : phase_reg;
        b_accum    = start_reg ? 64'd0 : accum_reg;
        b_shift    = start_reg ? 7'd0 : shift_reg;
        b_rem      = start_reg ? 32'd0 : rem_reg;
        b_pend     = start_reg ? 8'd0 : pend_reg;
        b_leb_done = start_reg ? 1'b0 : leb_done_reg;
        b_err      = start_reg ? 1'b0 : err_reg;

        leb_acc   = b_accum | (b_shift[6] ? 64'd0 : ({57'd0, b[6:0]} << b_shift[5:0]));
        leb_shift = (b_shift < 7'd70) ? (b_shift + 7'd7) : b_shift;
        leb_last  = !b[7];
        v         = leb_acc;
        r_dec     = b_rem - 32'd1;

        d_sel = cmd.div_by_range ? range_eff : mops_eff;
        r9    = {drem_reg, dvd_reg[63]};
        qbit  = (r9 >= {1'b0, d_sel});
        t9    = {1'b0, op_idx_reg} + {1'b0, drem_reg};

        unique case (cmd.code)
            CMD_STEP:
            begin
                addr_next     = b_addr;
                op_idx_next   = b_op;
                file_next     = b_file;
                line_next     = b_line;
                col_next      = b_col;
                isa_next      = b_isa;
                disc_next     = b_disc;
                flags_next    = b_flags;
                phase_next    = b_phase;
                accum_next    = b_accum;
                shift_next    = b_shift;
                rem_next      = b_rem;
                pend_next     = b_pend;
                leb_done_next = b_leb_done;
                err_next      = b_err;
                drem_next     = 8'd0;

                unique case (b_phase)
                    PH_LEB:
                    begin
                        accum_next = leb_acc;
                        shift_next = leb_shift;
                        if (leb_last)
                        begin
                            if (b_pend == OP_ADVANCE_LINE && b[6] && !leb_shift[6])
                            begin
                                v = leb_acc | (~64'd0 << leb_shift[5:0]);
                            end
                            accum_next = v;
                            phase_next = PH_OPCODE;
                            unique case (b_pend)
                                OP_ADVANCE_PC:
                                begin
                                    seq      = SEQ_ADVANCE;
                                    dvd_next = v;
                                end
                                OP_ADVANCE_LINE: line_next = LB'(b_line + LB'(v));
                                OP_SET_FILE:     file_next = 32'(v);
                                OP_SET_COLUMN:   col_next  = 16'(v);
                                default:         isa_next  = 8'(v);
                            endcase
                        end
                    end
                    PH_FIX_LO:
                    begin
                        accum_next = {56'd0, b};
                        phase_next = PH_FIX_HI;
                    end
                    PH_FIX_HI:
                    begin
                        addr_next   = AW'(b_addr + AW'(b_accum | ({56'd0, b} << 8)));
                        op_idx_next = 8'd0;
                        phase_next  = PH_OPCODE;
                    end
                    PH_EXT_LEN:
                    begin
                        accum_next = leb_acc;
                        shift_next = leb_shift;
                        if (leb_last)
                        begin
                            rem_next   = (|leb_acc[63:32]) ? 32'hFFFF_FFFF : leb_acc[31:0];
                            phase_next = (rem_next != 32'd0) ? PH_EXT_SUB : PH_OPCODE;
                        end
                    end
                    PH_EXT_SUB:
                    begin
                        rem_next      = r_dec;
                        pend_next     = b;
                        phase_next    = PH_EXT_BODY;
                        accum_next    = 64'd0;
                        shift_next    = 7'd0;
                        leb_done_next = 1'b0;
                        if (b == EXT_END_SEQUENCE)
                        begin
                            emit     = 1'b1;
                            out_next = make_row(b_addr, b_file, b_line, b_col,
                                                b_flags | 5'(1 << FL_END), b_isa, b_disc, b_err);
                            addr_next   = '0;
                            op_idx_next = 8'd0;
                            file_next   = 32'd1;
                            line_next   = LB'(1);
                            col_next    = 16'd0;
                            isa_next    = 8'd0;
                            disc_next   = 32'd0;
                            flags_next  = {4'd0, def_stmt_reg};
                        end
                        else if (b == EXT_SET_ADDRESS)
                        begin
                            if (r_dec != 32'd4 && r_dec != 32'd8)
                            begin
                                err_next  = 1'b1;
                                pend_next = 8'd0;
                            end
                        end
                        else if (b != EXT_DEFINE_FILE && b != EXT_SET_DISCRIM)
                        begin
                            err_next = 1'b1;
                        end
                        if (r_dec == 32'd0)
                        begin
                            phase_next = PH_OPCODE;
                            if (pend_next == EXT_SET_ADDRESS)
                            begin
                                addr_next   = '0;
                                op_idx_next = 8'd0;
                            end
                            else if (pend_next == EXT_SET_DISCRIM)
                            begin
                                disc_next = 32'd0;
                            end
                        end
                    end
                    PH_EXT_BODY:
                    begin
                        rem_next = r_dec;
                        if (b_pend == EXT_SET_ADDRESS)
                        begin
                            if (!b_shift[6])
                            begin
                                accum_next = b_accum | ({56'd0, b} << b_shift[5:0]);
                            end
                            shift_next = b_shift + 7'd8;
                        end
                        else if (b_pend == EXT_SET_DISCRIM && !b_leb_done)
                        begin
                            accum_next    = leb_acc;
                            shift_next    = leb_shift;
                            leb_done_next = leb_last;
                        end
                        if (r_dec == 32'd0)
                        begin
                            phase_next = PH_OPCODE;
                            if (b_pend == EXT_SET_ADDRESS)
                            begin
                                addr_next   = AW'(accum_next);
                                op_idx_next = 8'd0;
                            end
                            else if (b_pend == EXT_SET_DISCRIM)
                            begin
                                disc_next = 32'(accum_next);
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_OPCODE;
                        if (b == OP_EXTENDED)
                        begin
                            phase_next    = PH_EXT_LEN;
                            accum_next    = 64'd0;
                            shift_next    = 7'd0;
                            leb_done_next = 1'b0;
                        end
                        else if (b >= first_spec_reg)
                        begin
                            seq      = SEQ_SPECIAL;
                            dvd_next = {56'd0, 8'(b - first_spec_reg)};
                        end
                        else
                        begin
                            unique case (b)
                                OP_COPY:
                                begin
                                    emit       = 1'b1;
                                    out_next   = make_row(b_addr, b_file, b_line, b_col,
                                                          b_flags, b_isa, b_disc, b_err);
                                    flags_next = b_flags & 5'(1 << FL_STMT);
                                    disc_next  = 32'd0;
                                end
                                OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE,
                                OP_SET_COLUMN, OP_SET_ISA:
                                begin
                                    pend_next     = b;
                                    phase_next    = PH_LEB;
                                    accum_next    = 64'd0;
                                    shift_next    = 7'd0;
                                    leb_done_next = 1'b0;
                                end
                                OP_NEGATE_STMT:  flags_next[FL_STMT] = !b_flags[FL_STMT];
                                OP_BASIC_BLOCK:  flags_next[FL_BB]   = 1'b1;
                                OP_CONST_ADD_PC:
                                begin
                                    seq      = SEQ_CONST;
                                    dvd_next = {56'd0, 8'(SPECIAL_TOP - first_spec_reg)};
                                end
                                OP_FIXED_ADV_PC:
                                begin
                                    phase_next    = PH_FIX_LO;
                                    accum_next    = 64'd0;
                                    shift_next    = 7'd0;
                                    leb_done_next = 1'b0;
                                end
                                OP_PROLOGUE_END: flags_next[FL_PRO]  = 1'b1;
                                OP_EPILOGUE_BEG: flags_next[FL_EPI]  = 1'b1;
                                default:         err_next            = 1'b1;
                            endcase
                        end
                    end
                endcase
            end
            CMD_DIV:
            begin
                // One restoring division step per cycle, quotient shifts into dvd.
                drem_next = qbit ? 8'(r9 - {1'b0, d_sel}) : r9[7:0];
                dvd_next  = {dvd_reg[62:0], qbit};
            end
            CMD_LINE:
            begin
                if (cmd.special)
                begin
                    line_next = LB'(line_reg + LB'(line_base_reg) + LB'(drem_reg));
                end
                drem_next = 8'd0;
            end
            CMD_FIX:
            begin
                if (t9 >= {1'b0, mops_eff})
                begin
                    tidx_next  = 8'(t9 - {1'b0, mops_eff});
                    mcand_next = dvd_reg + 64'd1;
                end
                else
                begin
                    tidx_next  = t9[7:0];
                    mcand_next = dvd_reg;
                end
                prod_next   = 64'd0;
                mplier_next = min_len_reg;
            end
            CMD_MUL:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[7:1]};
            end
            CMD_COMMIT:
            begin
                addr_next   = AW'(addr_reg + AW'(prod_reg));
                op_idx_next = tidx_reg;
                if (cmd.special)
                begin
                    emit       = 1'b1;
                    out_next   = make_row(addr_next, file_reg, line_reg, col_reg,
                                          flags_reg, isa_reg, disc_reg, err_reg);
                    flags_next = flags_reg & 5'(1 << FL_STMT);
                    disc_next  = 32'd0;
                end
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            op_idx_reg    <= 8'd0;
            file_reg      <= 32'd1;
            line_reg      <= LB'(1);
            col_reg       <= 16'd0;
            isa_reg       <= 8'd0;
            disc_reg      <= 32'd0;
            flags_reg     <= 5'(1 << FL_STMT);
            phase_reg     <= PH_OPCODE;
            accum_reg     <= 64'd0;
            shift_reg     <= 7'd0;
            rem_reg       <= 32'd0;
            pend_reg      <= 8'd0;
            leb_done_reg  <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            op_idx_reg    <= op_idx_next;
            file_reg      <= file_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            isa_reg       <= isa_next;
            disc_reg      <= disc_next;
            flags_reg     <= flags_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            shift_reg     <= shift_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            leb_done_reg  <= leb_done_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == CMD_LOAD)
        begin
            byte_reg  <= in_data.program_byte;
            start_reg <= in_data.unit_start;
        end
        dvd_reg    <= dvd_next;
        drem_reg   <= drem_next;
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
        mplier_reg <= mplier_next;
        tidx_reg   <= tidx_next;
        out_reg    <= out_next;
    end

    assign status.seq      = seq;
    assign status.out_busy = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

// ===== design/debug_line_program_decoder_top.sv =====
// Top level of the debug line program decoder.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Word
//  in        into       in_valid / in_stall  in_data: program_byte, unit_start
//  out       out of     out_valid/ out_stall out_data: one line table row
//  cfg       into       cfg_we               cfg_index, cfg_data
//
// A byte that only updates state is first accepted and then decoded. The last
// operand byte of advance_pc runs one division by max_ops_per_inst and then the
// multiply. A special opcode and const_add_pc divide first by line_range and
// then by max_ops_per_inst. All of them use the shared bit-serial divider
// (64 steps per division) and the 8-step shift-add multiply by min_inst_length.
// The output row sits in a register, so the next byte is accepted while a row
// waits; that byte then waits in its decode cycle until the row register is empty.
// Reset is asynchronous and active low; it restores the configuration defaults
// and the initial line state.
module debug_line_program_decoder_top #(
    parameter int ADDRESS_BITS = 64,
    parameter int LINE_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dlpd_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dlpd_pkg::out_word_t                 out_data,
    input  logic                                cfg_we,
    input  logic [dlpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dlpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import dlpd_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    dp_cmd_t    cmd;
    dp_status_t status;

    dlpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds all line state, the divider, the multiplier and the
    // output row register.
    dlpd_datapath #(
        .AW (ADDRESS_BITS),
        .LB (LINE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/dlpd_checker.sv =====
// Port-level checks for the debug line program decoder and their bind.
`timescale 1ns / 1ps
module dlpd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input dlpd_pkg::out_word_t out_data
);
    import dlpd_pkg::*;

    // A held row stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("row dropped while stalled");

    // A held row does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("row changed while stalled");

    // After taking a byte the block is busy decoding it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted a byte without a decode cycle");

    // A new row appears only out of a decode cycle.
    a_row_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("row appeared while idle");

endmodule

bind debug_line_program_decoder_top dlpd_checker u_dlpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
